[rtl/jts_pkg.sv]
// ----------------------------------------------------------------------------
// JPEG trailer screen package
// Shared widths, marker bytes, signature tables, verdict codes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package jts_pkg;

  localparam int CountBits = 32;
  localparam int WideBits  = (CountBits > 32) ? CountBits : 32;
  localparam int CfgIndexBits = 1;
  localparam int CfgDataBits  = 32;

  localparam logic [CfgIndexBits-1:0] CfgMinScanBytes    = 1'd0;
  localparam logic [CfgIndexBits-1:0] CfgMaxTrailerBytes = 1'd1;

  localparam logic [15:0] MinScanReset    = 16'd32;
  localparam logic [31:0] MaxTrailerReset = 32'd4096;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] MarkerSos    = 8'hDA;

  localparam int NumSigs = 8;

  localparam logic [55:0] SigValue [NumSigs] = '{
    56'h0000_0050_4B03_04, 56'h0000_0000_001F_8B, 56'h0000_007F_454C_46,
    56'h0000_0000_004D_5A, 56'h0000_2550_4446_2D, 56'h0000_0000_0023_21,
    56'h0000_3C3F_7068_70, 56'h3C73_6372_6970_74
  };

  localparam logic [55:0] SigMask [NumSigs] = '{
    56'h0000_00FF_FFFF_FF, 56'h0000_0000_00FF_FF, 56'h0000_00FF_FFFF_FF,
    56'h0000_0000_00FF_FF, 56'h0000_FFFF_FFFF_FF, 56'h0000_0000_00FF_FF,
    56'h0000_FFFF_FFFF_FF, 56'hFFFF_FFFF_FFFF_FF
  };

  localparam logic [2:0] SigLen [NumSigs] = '{
    3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd2, 3'd5, 3'd7
  };

  // Signatures that end on the same byte start earlier when they are longer,
  // so this order picks the earliest start with ties by table index.
  localparam logic [2:0] SigOrder [NumSigs] = '{
    3'd7, 3'd4, 3'd6, 3'd0, 3'd2, 3'd1, 3'd3, 3'd5
  };

  typedef enum logic [2:0] {
    ReasonOk          = 3'd0,
    ReasonNoScan      = 3'd1,
    ReasonShortScan   = 3'd2,
    ReasonSignature   = 3'd3,
    ReasonLongTrailer = 3'd4
  } reason_e;

  function automatic logic [31:0] clip_count(logic [WideBits-1:0] x);
    return (x > WideBits'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/jts_if.sv]
// ----------------------------------------------------------------------------
// JPEG trailer screen channels
// Valid/ready channels for the byte stream and for the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface jts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface jts_verdict_if;
  logic        valid;
  logic        ready;
  logic        flagged;
  logic [2:0]  reason;
  logic [2:0]  signature;
  logic [31:0] count;

  modport source (output valid, output flagged, output reason, output signature,
                  output count, input ready);
  modport sink   (input valid, input flagged, input reason, input signature,
                  input count, output ready);
endinterface

`default_nettype wire

[rtl/jpeg_trailer_screen.sv]
// ----------------------------------------------------------------------------
// JPEG trailer screen
// Screens a JPEG file for data hidden after its end-of-image marker.
// The file enters on byte_i, one byte per transaction, with last set on the
// final byte. A byte can be accepted each cycle, but a final byte can be held back.
// The first two bytes are skipped, the marker segments are walked up to the
// start of scan, and in the scan region the latest EOI is tracked while eight
// signature comparators watch the bytes that follow it.
// One verdict transaction leaves on verdict_o for the final byte, in the cycle
// after that byte is accepted, from a single output register. All per-file
// state then returns to its reset value; the two configuration registers
// (written through cfg_we_i, cfg_index_i, cfg_wdata_i) are kept.
// While the verdict waits for verdict_o.ready, byte_i still accepts bytes
// that are not the final one; a final byte waits until the verdict register
// is free or is being emptied in the same cycle.
// Reset clears the parser state and loads min_scan_bytes = 32 and
// max_trailer_bytes = 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_trailer_screen (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [jts_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  wire logic [jts_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  jts_byte_if.sink                                byte_i,
  jts_verdict_if.source                           verdict_o
);

  localparam int CB = jts_pkg::CountBits;
  localparam int WB = jts_pkg::WideBits;

  typedef enum logic [2:0] {
    PhPreamble = 3'd0,
    PhHeader   = 3'd1,
    PhSegSkip  = 3'd2,
    PhSosSkip  = 3'd3,
    PhScan     = 3'd4,
    PhFailed   = 3'd5
  } phase_e;

  logic [15:0] min_scan_q;
  logic [31:0] max_trailer_q;

  phase_e        phase_q, phase_d;
  logic [1:0]    fidx_q, fidx_d;
  logic [7:0]    marker_q, marker_d;
  logic [15:0]   seg_rem_q, seg_rem_d;
  logic [CB-1:0] scan_cnt_q, scan_cnt_d;
  logic          prev_ff_q, prev_ff_d;
  logic          eoi_q, eoi_d;
  logic [CB-1:0] trl_cnt_q, trl_cnt_d;
  logic [47:0]   hist_q;
  logic          mvalid_q, mvalid_d;
  logic [CB-1:0] moff_q, moff_d;
  logic [2:0]    midx_q, midx_d;

  logic        out_valid_q;
  logic        out_flag_q;
  logic [2:0]  out_reason_q;
  logic [2:0]  out_sig_q;
  logic [31:0] out_count_q;

  logic          in_acc;
  logic          final_acc;
  logic [7:0]    b;
  logic [55:0]   window;
  logic [15:0]   seg_len;
  logic [15:0]   rem_dec;
  logic [CB-1:0] scan_inc;
  logic [CB-1:0] trl_inc;
  logic [jts_pkg::NumSigs-1:0] hit;
  logic          sel_hit;
  logic [2:0]    sel_idx;
  logic [CB-1:0] sel_off;

  jts_pkg::reason_e reason_n;
  logic [2:0]       sig_n;
  logic [WB-1:0]    count_n;

  assign b         = byte_i.data_byte;
  assign window    = {hist_q, b};
  assign in_acc    = byte_i.valid && byte_i.ready;
  assign final_acc = in_acc && byte_i.last;
  assign byte_i.ready = !out_valid_q || verdict_o.ready || !byte_i.last;

  assign seg_len  = {seg_rem_q[7:0], b};
  assign rem_dec  = (seg_rem_q != 16'd0) ? seg_rem_q - 16'd1 : seg_rem_q;
  assign scan_inc = (scan_cnt_q != '1) ? scan_cnt_q + CB'(1) : scan_cnt_q;
  assign trl_inc  = (trl_cnt_q != '1) ? trl_cnt_q + CB'(1) : trl_cnt_q;

  always_comb begin
    for (int k = 0; k < jts_pkg::NumSigs; k++) begin
      hit[k] = ((window & jts_pkg::SigMask[k]) == jts_pkg::SigValue[k]) &&
               (trl_inc >= CB'(jts_pkg::SigLen[k]));
    end
  end

  always_comb begin
    sel_hit = 1'b0;
    sel_idx = 3'd0;
    for (int i = jts_pkg::NumSigs - 1; i >= 0; i--) begin
      if (hit[jts_pkg::SigOrder[i]]) begin
        sel_hit = 1'b1;
        sel_idx = jts_pkg::SigOrder[i];
      end
    end
  end

  assign sel_off = trl_inc - CB'(jts_pkg::SigLen[sel_idx]);

  always_comb begin
    phase_d    = phase_q;
    fidx_d     = fidx_q;
    marker_d   = marker_q;
    seg_rem_d  = seg_rem_q;
    scan_cnt_d = scan_cnt_q;
    prev_ff_d  = prev_ff_q;
    eoi_d      = eoi_q;
    trl_cnt_d  = trl_cnt_q;
    mvalid_d   = mvalid_q;
    moff_d     = moff_q;
    midx_d     = midx_q;
    case (phase_q)
      PhPreamble: begin
        if (fidx_q == 2'd0) begin
          fidx_d = 2'd1;
        end else begin
          fidx_d  = 2'd0;
          phase_d = PhHeader;
        end
      end
      PhHeader: begin
        case (fidx_q)
          2'd0: begin
            if (b != jts_pkg::MarkerPrefix) begin
              phase_d = PhFailed;
            end else begin
              fidx_d = 2'd1;
            end
          end
          2'd1: begin
            if (b == jts_pkg::MarkerEoi) begin
              phase_d = PhFailed;
            end else begin
              marker_d = b;
              fidx_d   = 2'd2;
            end
          end
          2'd2: begin
            seg_rem_d = {8'd0, b};
            fidx_d    = 2'd3;
          end
          default: begin
            fidx_d = 2'd0;
            if (seg_len < 16'd2) begin
              phase_d = PhFailed;
            end else begin
              seg_rem_d = seg_len - 16'd2;
              if (marker_q == jts_pkg::MarkerSos) begin
                phase_d = (seg_len == 16'd2) ? PhScan : PhSosSkip;
              end else if (seg_len != 16'd2) begin
                phase_d = PhSegSkip;
              end
            end
          end
        endcase
      end
      PhSegSkip, PhSosSkip: begin
        seg_rem_d = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_d = (phase_q == PhSosSkip) ? PhScan : PhHeader;
        end
      end
      PhScan: begin
        scan_cnt_d = scan_inc;
        if (prev_ff_q && b == jts_pkg::MarkerEoi) begin
          eoi_d     = 1'b1;
          trl_cnt_d = '0;
          mvalid_d  = 1'b0;
          moff_d    = '0;
          midx_d    = 3'd0;
        end else if (eoi_q) begin
          trl_cnt_d = trl_inc;
          if (sel_hit && (!mvalid_q || sel_off < moff_q)) begin
            mvalid_d = 1'b1;
            moff_d   = sel_off;
            midx_d   = sel_idx;
          end
        end
        prev_ff_d = (b == jts_pkg::MarkerPrefix);
      end
      default: begin
        phase_d = PhFailed;
      end
    endcase
  end

  always_comb begin
    reason_n = jts_pkg::ReasonOk;
    sig_n    = 3'd0;
    count_n  = '0;
    if (phase_d != PhScan) begin
      reason_n = jts_pkg::ReasonNoScan;
    end else if (WB'(scan_cnt_d) < WB'(min_scan_q)) begin
      reason_n = jts_pkg::ReasonShortScan;
      count_n  = WB'(scan_cnt_d);
    end else if (eoi_d && mvalid_d) begin
      reason_n = jts_pkg::ReasonSignature;
      sig_n    = midx_d;
      count_n  = WB'(moff_d);
    end else if (eoi_d && WB'(trl_cnt_d) > WB'(max_trailer_q)) begin
      reason_n = jts_pkg::ReasonLongTrailer;
      count_n  = WB'(trl_cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_scan_q    <= jts_pkg::MinScanReset;
      max_trailer_q <= jts_pkg::MaxTrailerReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jts_pkg::CfgMinScanBytes:    min_scan_q    <= cfg_wdata_i[15:0];
        jts_pkg::CfgMaxTrailerBytes: max_trailer_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhPreamble;
      fidx_q     <= 2'd0;
      marker_q   <= 8'd0;
      seg_rem_q  <= 16'd0;
      scan_cnt_q <= '0;
      prev_ff_q  <= 1'b0;
      eoi_q      <= 1'b0;
      trl_cnt_q  <= '0;
      hist_q     <= 48'd0;
      mvalid_q   <= 1'b0;
      moff_q     <= '0;
      midx_q     <= 3'd0;
    end else if (in_acc) begin
      if (byte_i.last) begin
        phase_q    <= PhPreamble;
        fidx_q     <= 2'd0;
        marker_q   <= 8'd0;
        seg_rem_q  <= 16'd0;
        scan_cnt_q <= '0;
        prev_ff_q  <= 1'b0;
        eoi_q      <= 1'b0;
        trl_cnt_q  <= '0;
        hist_q     <= 48'd0;
        mvalid_q   <= 1'b0;
        moff_q     <= '0;
        midx_q     <= 3'd0;
      end else begin
        phase_q    <= phase_d;
        fidx_q     <= fidx_d;
        marker_q   <= marker_d;
        seg_rem_q  <= seg_rem_d;
        scan_cnt_q <= scan_cnt_d;
        prev_ff_q  <= prev_ff_d;
        eoi_q      <= eoi_d;
        trl_cnt_q  <= trl_cnt_d;
        hist_q     <= window[47:0];
        mvalid_q   <= mvalid_d;
        moff_q     <= moff_d;
        midx_q     <= midx_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (final_acc) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (final_acc) begin
      out_flag_q   <= (reason_n != jts_pkg::ReasonOk);
      out_reason_q <= reason_n;
      out_sig_q    <= sig_n;
      out_count_q  <= jts_pkg::clip_count(count_n);
    end
  end

  assign verdict_o.valid     = out_valid_q;
  assign verdict_o.flagged   = out_flag_q;
  assign verdict_o.reason    = out_reason_q;
  assign verdict_o.signature = out_sig_q;
  assign verdict_o.count     = out_count_q;

`ifndef ASSERT_OFF
  a_final_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_acc |=> out_valid_q)
    else $error("final byte accepted without a verdict being held");

  a_final_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_acc |=> (phase_q == PhPreamble) && (fidx_q == 2'd0) && !eoi_q && !mvalid_q)
    else $error("per-file state not cleared after the final byte");

  a_flag_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_flag_q == (out_reason_q != jts_pkg::ReasonOk)))
    else $error("flagged disagrees with reason");

  a_sig_only_for_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_reason_q != jts_pkg::ReasonSignature) |-> (out_sig_q == 3'd0))
    else $error("signature index set without a signature verdict");

  a_match_needs_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvalid_q |-> eoi_q)
    else $error("signature match recorded before any EOI");
`endif

endmodule

`default_nettype wire
